FILE: design/lkvc_pkg.sv
// Shared constants, types and codes for the LRU key/value cache.
// Used by lkvc_ctrl, lkvc_datapath and lru_key_value_cache.
package lkvc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 5;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W       = (OCC_W > CFG_W) ? OCC_W : CFG_W;

    localparam logic [CFG_W-1:0]  CAP_RESET = CFG_W'(16);
    localparam logic              CMD_GET   = 1'b0;
    localparam logic              CMD_SET   = 1'b1;
    localparam logic [DATA_W-1:0] READ_MISS = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic lookup;
        logic update;
        logic load_out;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_get;
    } dp_status_t;

endpackage

FILE: design/lkvc_ctrl.sv
// Sequencer for the LRU cache: input/output handshakes and lookup/update steps.
// Depends on lkvc_pkg.
module lkvc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  lkvc_pkg::dp_status_t status,
    output lkvc_pkg::dp_cmd_t    cmd
);
    import lkvc_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_busy;
    logic   upd_go;
    logic   accept;

    // a get may not finish while the previous result is still held
    assign out_busy = out_valid_reg && out_stall;
    assign upd_go   = !(status.req_get && out_busy);
    assign in_stall = !((state_reg == ST_IDLE) || ((state_reg == ST_UPDATE) && upd_go));
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_go)
                begin
                    state_next = accept ? ST_LOOKUP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update   = upd_go;
                cmd.load_out = upd_go && status.req_get;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: design/lkvc_datapath.sv
// Entry store, parallel key compare, recency ranks and result register.
// Depends on lkvc_pkg; driven by lkvc_ctrl.
module lkvc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lkvc_pkg::dp_cmd_t           cmd,
    output lkvc_pkg::dp_status_t        status,
    input  logic                        cfg_we,
    input  logic [lkvc_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        command,
    input  logic [lkvc_pkg::KEY_W-1:0]  key,
    input  logic [lkvc_pkg::DATA_W-1:0] value,
    output logic                        hit,
    output logic [lkvc_pkg::DATA_W-1:0] read_value
);
    import lkvc_pkg::*;

    logic [KEY_W-1:0]  keys_reg   [MAX_ENTRIES];
    logic [DATA_W-1:0] values_reg [MAX_ENTRIES];
    logic [IDX_W-1:0]  ranks_reg  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [CFG_W-1:0]  cap_reg;

    logic              req_cmd_reg;
    logic [KEY_W-1:0]  req_key_reg;
    logic [DATA_W-1:0] req_value_reg;

    logic              lk_hit_reg;
    logic              lk_insert_reg;
    logic [IDX_W-1:0]  lk_slot_reg;
    logic [OCC_W-1:0]  lk_rank_reg;

    logic              hit_reg;
    logic [DATA_W-1:0] read_value_reg;

    logic              lk_hit;
    logic [IDX_W-1:0]  hit_slot;
    logic [IDX_W-1:0]  hit_rank;
    logic [IDX_W-1:0]  lru_slot;
    logic [IDX_W-1:0]  free_slot;
    logic [OCC_W-1:0]  occ_last;
    logic [CMP_W-1:0]  eff_cap;
    logic              room;
    logic              is_set;
    logic              touch;

    assign occ_last = occ_reg - OCC_W'(1);
    assign is_set   = (req_cmd_reg == CMD_SET);
    assign touch    = cmd.update && (is_set || lk_hit_reg);
    assign status.req_get = (req_cmd_reg == CMD_GET);

    // capacity clamped to 1..MAX_ENTRIES
    always_comb
    begin
        eff_cap = CMP_W'(cap_reg);
        if (eff_cap == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (eff_cap > CMP_W'(MAX_ENTRIES))
        begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end
    end

    assign room = CMP_W'(occ_reg) < eff_cap;

    // keys are unique among valid entries, so matches are one-hot and OR-encode.
    // The LRU entry is the valid one whose rank is occupancy-1.
    always_comb
    begin
        lk_hit    = 1'b0;
        hit_slot  = '0;
        hit_rank  = '0;
        lru_slot  = '0;
        free_slot = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (valid_reg[i] && (keys_reg[i] == req_key_reg))
            begin
                lk_hit   = 1'b1;
                hit_slot = hit_slot | IDX_W'(i);
                hit_rank = hit_rank | ranks_reg[i];
            end
            if (valid_reg[i] && (OCC_W'(ranks_reg[i]) == occ_last))
            begin
                lru_slot = lru_slot | IDX_W'(i);
            end
        end
        for (int i = MAX_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_cmd_reg   <= command;
            req_key_reg   <= key;
            req_value_reg <= value;
        end
        if (cmd.lookup)
        begin
            lk_hit_reg    <= lk_hit;
            lk_insert_reg <= !lk_hit && room;
            if (lk_hit)
            begin
                lk_slot_reg <= hit_slot;
                lk_rank_reg <= OCC_W'(hit_rank);
            end
            else if (room)
            begin
                lk_slot_reg <= free_slot;
                lk_rank_reg <= occ_reg;
            end
            else
            begin
                lk_slot_reg <= lru_slot;
                lk_rank_reg <= occ_last;
            end
        end
        if (cmd.load_out)
        begin
            hit_reg        <= lk_hit_reg;
            read_value_reg <= lk_hit_reg ? values_reg[lk_slot_reg] : READ_MISS;
        end
    end

    // entry payload: keys, values and ranks carry no reset
    always_ff @(posedge clk)
    begin
        if (cmd.update && is_set && !lk_hit_reg)
        begin
            keys_reg[lk_slot_reg] <= req_key_reg;
        end
        if (cmd.update && is_set)
        begin
            values_reg[lk_slot_reg] <= req_value_reg;
        end
        for (int j = 0; j < MAX_ENTRIES; j++)
        begin
            if (touch)
            begin
                if (IDX_W'(j) == lk_slot_reg)
                begin
                    ranks_reg[j] <= '0;
                end
                else if (valid_reg[j] && (OCC_W'(ranks_reg[j]) < lk_rank_reg))
                begin
                    ranks_reg[j] <= ranks_reg[j] + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            cap_reg   <= CAP_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.update && is_set && lk_insert_reg)
            begin
                valid_reg[lk_slot_reg] <= 1'b1;
                occ_reg                <= occ_reg + OCC_W'(1);
            end
        end
    end

    assign hit        = hit_reg;
    assign read_value = read_value_reg;

endmodule

FILE: design/lru_key_value_cache.sv
// Top level of the LRU key/value cache: controller, datapath, assertions.
// Depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath.

// Fully associative 16-entry key/value cache with LRU replacement. A get
// (command 0) returns one word: hit and the stored value, or hit clear and
// read_value all ones; a set (command 1) updates or inserts and returns
// nothing. Each item passes a lookup step, the parallel compare of the key
// against all entries, and an update step, the recency-rank update and store
// write; the next item is accepted in the update cycle. A get also holds in
// its update cycle while the previous result waits behind out_stall. The
// result word is loaded into the result register in the get's update step.
// capacity_in_use is written through cfg_data (low 5 bits, reset 16); 0
// behaves as 1, values above 16 as 16. Write it only while the block is idle.
module lru_key_value_cache (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lkvc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               command,
    input  logic signed [lkvc_pkg::KEY_W-1:0]  key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               hit,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value
);
    import lkvc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_accept;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && !in_stall;

    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lkvc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .command    (command),
        .key        (key),
        .value      (value),
        .hit        (hit),
        .read_value (read_value)
    );

    // no new word while the compare step is in flight
    a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |-> in_stall)
        else $error("input accepted during lookup");

    a_accept_then_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> cmd.lookup)
        else $error("accepted word not looked up next cycle");

    a_lookup_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.lookup |=> !cmd.lookup)
        else $error("lookup repeated");

    // a pending result is never overwritten
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !(out_valid && out_stall))
        else $error("result register overwritten while held");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for lru_key_value_cache: directed table, then random get/set traffic.
// Depends on lkvc_pkg and the lru_key_value_cache RTL; carries its own LRU cache predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lkvc_pkg::*;

    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int DIRECTED_ROWS   = 22;

    typedef enum logic {ROW_ITEM, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               cmd;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  value;   // capacity on ROW_CAP rows
        logic               typed;   // expected word given in the row
        logic               exp_hit;
        logic [DATA_W-1:0]  exp_value;
    } stim_row_t;

    typedef struct packed {
        logic              hit;
        logic [DATA_W-1:0] value;
    } read_word_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic                     command;
    logic signed [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
    logic                     out_valid;
    logic                     out_stall;
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;

    lru_key_value_cache dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .key        (key),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .read_value (read_value)
    );

    // predicted cache contents
    logic [CFG_W-1:0]  cap_in_use = CAP_RESET;
    logic [KEY_W-1:0]  slot_key   [MAX_ENTRIES];
    logic [DATA_W-1:0] slot_data  [MAX_ENTRIES];
    logic              slot_valid [MAX_ENTRIES] = '{default: 1'b0};
    logic [IDX_W-1:0]  slot_rank  [MAX_ENTRIES] = '{default: '0};
    logic [OCC_W-1:0]  occupancy  = '0;

    read_word_t pending_reads[$];
    int         mismatches  = 0;
    int         reads_seen  = 0;
    int         cycle_count = 0;
    bit         idle_on     = 1'b1;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{ROW_ITEM, CMD_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b0, READ_MISS},
        '{ROW_ITEM, CMD_GET, 32'h8000_0000, 32'h0, 1'b1, 1'b0, READ_MISS},
        '{ROW_ITEM, CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'h8000_0000},
        '{ROW_ITEM, CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
        '{ROW_ITEM, CMD_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b1, 32'hFFFF_FFFF},
        '{ROW_ITEM, CMD_SET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h0000_0000, 32'h0, 1'b1, 1'b1, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, READ_MISS},
        // capacity dropped below the three entries held
        '{ROW_CAP,  CMD_GET, 32'h0, 32'd1, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_SET, 32'h0000_0005, 32'd55, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h0000_0005, 32'h0, 1'b1, 1'b1, 32'd55},
        '{ROW_ITEM, CMD_GET, 32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0},
        // zero capacity acts as one
        '{ROW_CAP,  CMD_GET, 32'h0, 32'd0, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_SET, 32'h0000_0006, 32'd66, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h0000_0006, 32'h0, 1'b1, 1'b1, 32'd66},
        '{ROW_ITEM, CMD_SET, 32'h0000_0000, 32'h5A5A_5A5A, 1'b0, 1'b0, 32'h0},
        // capacity above the table size acts as the table size
        '{ROW_CAP,  CMD_GET, 32'h0, 32'd31, 1'b0, 1'b0, 32'h0},
        '{ROW_ITEM, CMD_GET, 32'h0000_0000, 32'h0, 1'b0, 1'b0, 32'h0}
    };

    // Make slot s the most recent entry.
    function automatic void promote_slot(input int s);
        logic [IDX_W-1:0] r;
        r = slot_rank[s];
        for (int j = 0; j < MAX_ENTRIES; j++)
            if (slot_valid[j] && slot_rank[j] < r)
                slot_rank[j]++;
        slot_rank[s] = '0;
    endfunction

    // Apply one get/set to the predicted cache; returns 1 when a read word is due.
    function automatic bit cache_access(input logic cmd, input logic [KEY_W-1:0] k,
                                        input logic [DATA_W-1:0] v, output read_word_t word);
        int               s;
        int               lim;
        logic [IDX_W-1:0] oldest;
        s = -1;
        word = '{hit: 1'b0, value: READ_MISS};
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (s < 0 && slot_valid[i] && slot_key[i] == k)
                s = i;
        if (cmd == CMD_GET)
        begin
            if (s >= 0)
            begin
                promote_slot(s);
                word = '{hit: 1'b1, value: slot_data[s]};
            end
            return 1'b1;
        end
        if (s >= 0)
        begin
            slot_data[s] = v;
            promote_slot(s);
            return 1'b0;
        end
        lim = (cap_in_use == 0) ? 1 : ((cap_in_use > MAX_ENTRIES) ? MAX_ENTRIES : cap_in_use);
        if (occupancy < lim)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (s < 0 && !slot_valid[i])
                    s = i;
        end
        if (s >= 0)
        begin
            for (int i = 0; i < MAX_ENTRIES; i++)
                if (slot_valid[i])
                    slot_rank[i]++;
            slot_valid[s] = 1'b1;
            slot_key[s]   = k;
            slot_data[s]  = v;
            slot_rank[s]  = '0;
            occupancy++;
            return 1'b0;
        end
        // full: evict the least recent entry
        oldest = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            if (slot_valid[i] && (s < 0 || slot_rank[i] > oldest))
            begin
                s = i;
                oldest = slot_rank[i];
            end
        if (s >= 0)
        begin
            slot_key[s]  = k;
            slot_data[s] = v;
            promote_slot(s);
        end
        return 1'b0;
    endfunction

    // Present one word and hold it until accepted. With typed set, the row's word
    // is expected in place of the predicted one.
    task automatic send_word(input logic cmd, input logic [KEY_W-1:0] k,
                             input logic [DATA_W-1:0] v, input bit typed,
                             input read_word_t typed_word);
        read_word_t word;
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (cache_access(cmd, k, v, word))
            pending_reads.push_back(typed ? typed_word : word);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // Capacity writes only once the cache has drained.
    task automatic set_capacity(input logic [CFG_W-1:0] c);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        cap_in_use = c;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("lru_key_value_cache: mismatch");
            $finish;
        end
    end

    // receiver stalls in bursts
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_on && rst_n && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        read_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            reads_seen++;
            if (pending_reads.size() == 0)
            begin
                if (mismatches < 10)
                    $display(
                        "%0t: read word %0d with none expected: hit=%0b value=%h",
                        $realtime, reads_seen, hit, read_value);
                mismatches++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (hit !== want.hit || read_value !== want.value)
                begin
                    if (mismatches < 10)
                        $display(
                            "%0t: read word %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                            $realtime, reads_seen, want.hit, want.value, hit, read_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [CFG_W-1:0]  c;
        logic              cmd;
        logic [KEY_W-1:0]  k;
        logic [KEY_W-1:0]  last_set_key;
        logic [KEY_W-1:0]  key_pool[$];
        int                pool_size;
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        command   <= CMD_GET;
        key       <= '0;
        value     <= '0;
        last_set_key = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CAP)
                set_capacity(directed_rows[i].value[CFG_W-1:0]);
            else
                send_word(directed_rows[i].cmd, directed_rows[i].key, directed_rows[i].value,
                          directed_rows[i].typed,
                          '{hit: directed_rows[i].exp_hit, value: directed_rows[i].exp_value});
        end

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: c = 5'd16;
                1: c = 5'd1;
                2: c = 5'd31;
                3: c = 5'd0;
                4: c = 5'd8;
                5: c = 5'd17;
                8: c = 5'd2;
                default: c = CFG_W'($urandom_range(0, 31));
            endcase
            set_capacity(c);
            idle_on = (p == PHASES - 1) ? 1'b0 : ($urandom_range(0, 4) != 0);
            // small key pool per phase so that hits, updates and evictions all happen
            key_pool.delete();
            pool_size = $urandom_range(2, 22);
            repeat (pool_size) key_pool.push_back($urandom());
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                cmd = $urandom_range(0, 1) ? CMD_SET : CMD_GET;
                if ($urandom_range(0, 6) == 0)
                    k = $urandom();
                else if (cmd == CMD_GET && $urandom_range(0, 2) == 0)
                    k = last_set_key;
                else
                    k = key_pool[$urandom_range(0, pool_size - 1)];
                if (cmd == CMD_SET)
                    last_set_key = k;
                send_word(cmd, k, $urandom(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("lru_key_value_cache: match");
        else
            $display("lru_key_value_cache: mismatch");
        $finish;
    end

endmodule
